[hw/rtl/rsg_pkg.sv]
// Shared types, constants and the arctangent table of the axial RoPE sin/cos generator.
package rsg_pkg;

	localparam int SideW   = 13;   // grid side and normalizer width
	localparam int PerW    = 32;   // period width, Q16.16
	localparam int DenW    = 45;   // side times period
	localparam int QuotN   = SideW + 48;   // divider stages: integer bits of m, then 48 fraction bits
	localparam int PhaseW  = 32;   // phase in 2^-32 turn
	localparam int CordW   = 35;   // CORDIC x, y, z width
	localparam int ValW    = 16;   // Q1.15 result
	localparam int PosW    = 24;
	localparam logic signed [CordW-1:0] CordX0 = 35'sd652032875;

	typedef enum logic [1:0] {
		CFG_GRID_HEIGHT = 2'd0,
		CFG_GRID_WIDTH  = 2'd1,
		CFG_NORM_MODE   = 2'd2,
		CFG_PERIOD_CNT  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		NORM_MIN  = 2'd0,
		NORM_MAX  = 2'd1,
		NORM_AXIS = 2'd2
	} norm_mode_t;

	// Fields that ride alongside the arithmetic.
	typedef struct packed {
		logic            valid;
		logic            bad;
		logic [7:0]      row_part;
		logic [8:0]      col_part;
		logic [PosW-1:0] pos;
	} side_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [PhaseW-1:0] atan_turns(input logic [4:0] i);
		logic [PhaseW-1:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/axial_rope_sincos_generator_top.sv]
// Top level of the axial RoPE sin/cos generator: front stages, two phase paths, output register.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+--------------------------------------------
//  in      | in        | in_valid / in_stall   | row, column, period_index, period
//  out     | out       | out_valid / out_stall | sin/cos row/col, position_index, columns, bad
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled; it passes the front stages,
// the 61 one-bit divider stages (13 integer, 48 fraction) plus its rounding stage, one
// stage per CORDIC step with the CORDIC output register, and the output register.
// Reset loads the configuration defaults and clears the used valid bits; data stages need none.
// A stall on the output freezes the whole pipeline at once while the output word is
// held, so in_stall follows it; bubbles are kept, nothing is dropped or repeated.
module axial_rope_sincos_generator_top #(
	parameter int MAX_GRID_SIDE = 4096,
	parameter int MAX_PERIODS   = 256,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [11:0]         row,
	input  logic [11:0]         column,
	input  logic [7:0]          period_index,
	input  logic [31:0]         period,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  sin_row,
	output logic signed [15:0]  cos_row,
	output logic signed [15:0]  sin_col,
	output logic signed [15:0]  cos_col,
	output logic [23:0]         position_index,
	output logic [7:0]          row_part_column,
	output logic [8:0]          col_part_column,
	output logic                bad_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int SW = rsg_pkg::SideW;
	localparam int DW = rsg_pkg::DenW;
	localparam int SB_DEPTH = rsg_pkg::QuotN + 1 + CORDIC_STEPS + 1;

	// configuration
	logic [SW-1:0] grid_height_q, grid_width_q;
	logic [1:0]    norm_mode_q;
	logic [8:0]    period_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_height_q  <= 13'd1;
			grid_width_q   <= 13'd1;
			norm_mode_q    <= rsg_pkg::NORM_AXIS;
			period_count_q <= 9'd1;
		end else if (cfg_valid) begin
			unique case (rsg_pkg::cfg_index_t'(cfg_index))
				rsg_pkg::CFG_GRID_HEIGHT: grid_height_q  <= cfg_data[SW-1:0];
				rsg_pkg::CFG_GRID_WIDTH:  grid_width_q   <= cfg_data[SW-1:0];
				rsg_pkg::CFG_NORM_MODE:   norm_mode_q    <= cfg_data[1:0];
				rsg_pkg::CFG_PERIOD_CNT:  period_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// global advance: hold everything while the output word is stalled
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// clamp sides and count, pick normalizers
	logic [SW-1:0] h, w, nh, nw;
	logic [8:0]    pc;
	logic          bad_in;
	always_comb begin
		h  = (32'(grid_height_q) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE) : grid_height_q;
		w  = (32'(grid_width_q) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE) : grid_width_q;
		pc = (32'(period_count_q) > MAX_PERIODS) ? 9'(MAX_PERIODS) : period_count_q;
		case (norm_mode_q)
			rsg_pkg::NORM_MIN: begin nh = (h < w) ? h : w; nw = nh; end
			rsg_pkg::NORM_MAX: begin nh = (h > w) ? h : w; nw = nh; end
			default:           begin nh = h; nw = w; end
		endcase
		bad_in = (period == 32'd0) || (SW'(row) >= h) || (SW'(column) >= w);
	end

	// stage 1: register the word with its normalizers and flat index
	logic                row_s1_v;
	logic                valid_s2;
	rsg_pkg::side_t      side_s1;
	logic [11:0]         row_s1, col_s1;
	logic [SW-1:0]       nh_s1, nw_s1;
	logic [31:0]         per_s1;
	logic [24:0]         pos_full;

	assign pos_full = 25'(row) * 25'(w) + 25'(column);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1_v <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			row_s1_v <= in_valid;
			valid_s2 <= row_s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.valid    <= in_valid;
			side_s1.bad      <= bad_in;
			side_s1.row_part <= period_index;
			side_s1.col_part <= pc + 9'(period_index);
			side_s1.pos      <= pos_full[23:0];
			row_s1 <= row;
			col_s1 <= column;
			nh_s1  <= nh;
			nw_s1  <= nw;
			per_s1 <= period;
		end
	end

	// stage 2: centred numerators and denominators
	logic signed [SW+1:0] num_r, num_c;
	assign num_r = (SW+2)'({row_s1, 1'b1}) - (SW+2)'(nh_s1);
	assign num_c = (SW+2)'({col_s1, 1'b1}) - (SW+2)'(nw_s1);

	rsg_pkg::side_t side_s2;
	logic [SW-1:0]  m_r_s2, m_c_s2;
	logic           neg_r_s2, neg_c_s2;
	logic [DW-1:0]  d_r_s2, d_c_s2;
	logic [SW+1:0]  abs_r, abs_c;

	assign abs_r = num_r[SW+1] ? -num_r : num_r;
	assign abs_c = num_c[SW+1] ? -num_c : num_c;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_s1;
			m_r_s2   <= abs_r[SW-1:0];
			m_c_s2   <= abs_c[SW-1:0];
			neg_r_s2 <= num_r[SW+1];
			neg_c_s2 <= num_c[SW+1];
			d_r_s2   <= DW'(nh_s1) * DW'(per_s1);
			d_c_s2   <= DW'(nw_s1) * DW'(per_s1);
		end
	end

	// sideband line matched to the divider and CORDIC latency; the valid bit comes
	// from the reset stage register
	rsg_pkg::side_t sb_s [0:SB_DEPTH];
	assign sb_s[0] = '{valid: valid_s2, bad: side_s2.bad, row_part: side_s2.row_part,
		col_part: side_s2.col_part, pos: side_s2.pos};

	for (genvar k = 0; k < SB_DEPTH; k++) begin : g_sb
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[k+1] <= '0;
			end else if (en) begin
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	// row and column phase paths
	logic [31:0] phase_r, phase_c;
	logic signed [15:0] s_r, c_r, s_c, c_c;

	rsg_divider u_div_row (
		.clk(clk), .en(en), .m(m_r_s2), .d(d_r_s2), .neg(neg_r_s2), .phase(phase_r)
	);
	rsg_divider u_div_col (
		.clk(clk), .en(en), .m(m_c_s2), .d(d_c_s2), .neg(neg_c_s2), .phase(phase_c)
	);
	rsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_row (
		.clk(clk), .en(en), .phase(phase_r), .sin_val(s_r), .cos_val(c_r)
	);
	rsg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_col (
		.clk(clk), .en(en), .phase(phase_c), .sin_val(s_c), .cos_val(c_c)
	);

	// output register: zero the values of a bad word
	rsg_pkg::side_t sb_end;
	logic           out_valid_q;
	assign sb_end = sb_s[SB_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sb_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_row         <= sb_end.bad ? 16'sd0 : s_r;
			cos_row         <= sb_end.bad ? 16'sd0 : c_r;
			sin_col         <= sb_end.bad ? 16'sd0 : s_c;
			cos_col         <= sb_end.bad ? 16'sd0 : c_c;
			position_index  <= sb_end.bad ? 24'd0 : sb_end.pos;
			row_part_column <= sb_end.row_part;
			col_part_column <= sb_end.col_part;
			bad_item        <= sb_end.bad;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/rsg_divider.sv]
// Pipelined restoring divider: rounded, signed phase of m * 2^48 / d, low 32 bits.
module rsg_divider (
	input  logic                           clk,
	input  logic                           en,
	input  logic [rsg_pkg::SideW-1:0]      m,
	input  logic [rsg_pkg::DenW-1:0]       d,
	input  logic                           neg,
	output logic [rsg_pkg::PhaseW-1:0]     phase
);

	localparam int N = rsg_pkg::QuotN;
	localparam int MW = rsg_pkg::SideW;
	localparam int DW = rsg_pkg::DenW;
	localparam int QW = rsg_pkg::PhaseW;

	logic [DW-1:0] rem_s [0:N];
	logic [DW-1:0] den_s [0:N];
	logic [QW-1:0] quo_s [0:N];
	logic [MW-1:0] m_s   [0:N];
	logic          neg_s [0:N];
	logic [QW-1:0] phase_q;

	assign rem_s[0] = '0;
	assign den_s[0] = d;
	assign quo_s[0] = '0;
	assign m_s[0]   = m;
	assign neg_s[0] = neg;

	// one quotient bit per stage; shift in the dividend bits, then zeros
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [DW:0] sh;
		logic [DW:0] diff;
		logic        take;
		assign sh   = {rem_s[k], m_s[k][MW-1]};
		assign diff = sh - {1'b0, den_s[k]};
		assign take = sh >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DW-1:0] : sh[DW-1:0];
				quo_s[k+1] <= {quo_s[k][QW-2:0], take};
				m_s[k+1]   <= {m_s[k][MW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	logic [QW-1:0] rounded;
	always_comb begin
		rounded = quo_s[N] + QW'({rem_s[N], 1'b0} >= {1'b0, den_s[N]});
		if (neg_s[N]) rounded = QW'(0) - rounded;
	end

	always_ff @(posedge clk) begin
		if (en) phase_q <= rounded;
	end

	assign phase = phase_q;

endmodule

[hw/rtl/rsg_cordic.sv]
// Pipelined rotation CORDIC with quadrant fold and Q1.15 rounding.
module rsg_cordic #(
	parameter int STEPS = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [rsg_pkg::PhaseW-1:0]         phase,
	output logic signed [rsg_pkg::ValW-1:0]    sin_val,
	output logic signed [rsg_pkg::ValW-1:0]    cos_val
);

	localparam int CW = rsg_pkg::CordW;
	localparam int VW = rsg_pkg::ValW;

	logic signed [CW-1:0] cx_s [0:STEPS];
	logic signed [CW-1:0] cy_s [0:STEPS];
	logic signed [CW-1:0] cz_s [0:STEPS];
	logic [1:0]           quad_s [0:STEPS];

	assign cx_s[0]   = rsg_pkg::CordX0;
	assign cy_s[0]   = '0;
	assign cz_s[0]   = CW'(phase[29:0]);
	assign quad_s[0] = phase[31:30];

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign at = CW'(rsg_pkg::atan_turns(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + at;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	function automatic logic signed [VW-1:0] to_q15(input logic signed [CW:0] v);
		logic signed [CW:0] r;
		r = (v + (CW+1)'(16384)) >>> 15;
		if (r > (CW+1)'(32767)) return 16'sh7fff;
		if (r < -(CW+1)'(32768)) return 16'sh8000;
		return r[VW-1:0];
	endfunction

	logic signed [CW:0] xe, ye, cv, sv;
	always_comb begin
		xe = (CW+1)'(cx_s[STEPS]);
		ye = (CW+1)'(cy_s[STEPS]);
		case (quad_s[STEPS])
			2'd0:    begin cv = xe;  sv = ye;  end
			2'd1:    begin cv = -ye; sv = xe;  end
			2'd2:    begin cv = -xe; sv = -ye; end
			default: begin cv = ye;  sv = -xe; end
		endcase
	end

	logic signed [VW-1:0] sin_q, cos_q;
	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= to_q15(sv);
			cos_q <= to_q15(cv);
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the axial RoPE sin/cos generator: predicted words vs. DUT output.
module testbench;

	localparam int LATENCY   = 2 + 62 + 16 + 1 + 1;
	localparam int MAX_CYCLE = 2000000;

	typedef struct {
		logic [11:0] row;
		logic [11:0] column;
		logic [7:0]  pidx;
		logic [31:0] period;
	} pos_word_t;

	typedef struct {
		logic signed [15:0] sin_r, cos_r, sin_c, cos_c;
		logic [23:0] pos;
		logic [7:0]  rpc;
		logic [8:0]  cpc;
		logic        bad;
	} embed_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [11:0] row = 0, column = 0;
	logic [7:0]  period_index = 0;
	logic [31:0] period = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] sin_row, cos_row, sin_col, cos_col;
	logic [23:0] position_index;
	logic [7:0]  row_part_column;
	logic [8:0]  col_part_column;
	logic bad_item;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0]  cfg_index = rsg_pkg::CFG_GRID_HEIGHT;
	logic [31:0] cfg_data = 0;

	axial_rope_sincos_generator_top DUT (.*);

	always #10 clk = ~clk;

	// Shadow of the configuration registers.
	logic [12:0] grid_h = 1, grid_w = 1;
	logic [1:0]  norm_sel = rsg_pkg::NORM_AXIS;
	logic [8:0]  period_cnt = 1;

	pos_word_t   pending_words[$];
	embed_word_t expected_embeds[$];
	int errors = 0;
	int words_sent = 0, words_seen = 0, bad_seen = 0;
	int cycle = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_input = 0;

	// Phase of (2x+1-n)/n over period, in 2^-32 turn, rounded half up on the magnitude.
	function automatic logic [31:0] turn_phase(logic [12:0] x, logic [12:0] n, logic [31:0] per);
		logic signed [15:0] num;
		logic [15:0] mag;
		logic [63:0] d, a, q, r;
		num = 16'(2 * int'(x) + 1 - int'(n));
		mag = num < 0 ? 16'(-num) : 16'(num);
		d = 64'(n) * 64'(per);
		a = 64'(mag) << 16;
		q = a / d;
		r = a % d;
		for (int i = 0; i < 32; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (2 * r >= d)
			q = q + 1;
		if (num < 0)
			q = -q;
		return q[31:0];
	endfunction

	function automatic logic signed [15:0] round_q15(longint v);
		longint t;
		t = (v + (64'sd1 <<< 14)) >>> 15;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return 16'(t);
	endfunction

	function automatic void rotate_turn(logic [31:0] ph, output logic signed [15:0] s,
			output logic signed [15:0] c);
		longint x, y, z, dx, dy, cx, sy;
		x = 652032875;
		y = 0;
		z = longint'(ph[29:0]);
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(rsg_pkg::atan_turns(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(rsg_pkg::atan_turns(5'(i)));
			end
		end
		case (ph[31:30])
			2'd0: begin cx = x;  sy = y;  end
			2'd1: begin cx = -y; sy = x;  end
			2'd2: begin cx = -x; sy = -y; end
			default: begin cx = y; sy = -x; end
		endcase
		s = round_q15(sy);
		c = round_q15(cx);
	endfunction

	function automatic embed_word_t predict_embed(pos_word_t w);
		embed_word_t e;
		logic [12:0] h, wd, nh, nw;
		logic [8:0]  pc;
		h  = grid_h > 4096 ? 13'd4096 : grid_h;
		wd = grid_w > 4096 ? 13'd4096 : grid_w;
		pc = period_cnt > 256 ? 9'd256 : period_cnt;
		e = '{default: '0};
		e.rpc = w.pidx;
		e.cpc = pc + 9'(w.pidx);
		e.bad = w.period == 0 || w.row >= h || w.column >= wd;
		if (e.bad)
			return e;
		if (norm_sel == rsg_pkg::NORM_MIN) begin
			nh = h < wd ? h : wd; nw = nh;
		end else if (norm_sel == rsg_pkg::NORM_MAX) begin
			nh = h > wd ? h : wd; nw = nh;
		end else begin
			nh = h; nw = wd;
		end
		rotate_turn(turn_phase(13'(w.row), nh, w.period), e.sin_r, e.cos_r);
		rotate_turn(turn_phase(13'(w.column), nw, w.period), e.sin_c, e.cos_c);
		e.pos = 24'(32'(w.row) * 32'(wd) + 32'(w.column));
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH word %0d %s: got %0d want %0d", words_seen, what, got, want);
		errors++;
	endtask

	// Driver: advance the next word when the current one is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && !hold_input
						&& $urandom_range(99) >= send_idle) begin
					pos_word_t w;
					w = pending_words.pop_front();
					expected_embeds.push_back(predict_embed(w));
					row <= w.row;
					column <= w.column;
					period_index <= w.pidx;
					period <= w.period;
					in_valid <= 1'b1;
					words_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= $urandom_range(99) < recv_idle;
		end
	end

	// Monitor: compare each accepted output word with the oldest prediction.
	always @(posedge clk) begin
		cycle++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_embeds.size() == 0) begin
				$display("MISMATCH unexpected output word");
				errors++;
			end else begin
				embed_word_t e;
				e = expected_embeds.pop_front();
				if (sin_row !== e.sin_r) report_mismatch("sin_row", sin_row, e.sin_r);
				if (cos_row !== e.cos_r) report_mismatch("cos_row", cos_row, e.cos_r);
				if (sin_col !== e.sin_c) report_mismatch("sin_col", sin_col, e.sin_c);
				if (cos_col !== e.cos_c) report_mismatch("cos_col", cos_col, e.cos_c);
				if (position_index !== e.pos)
					report_mismatch("position_index", position_index, e.pos);
				if (row_part_column !== e.rpc)
					report_mismatch("row_part_column", row_part_column, e.rpc);
				if (col_part_column !== e.cpc)
					report_mismatch("col_part_column", col_part_column, e.cpc);
				if (bad_item !== e.bad) report_mismatch("bad_item", bad_item, e.bad);
				if (bad_item) bad_seen++;
			end
			words_seen++;
		end
		if (cycle > MAX_CYCLE) begin
			$display("timeout with %0d words outstanding", expected_embeds.size());
			$display("axial_rope_sincos_generator_top test failed");
			$finish;
		end
	end

	// Write one register while the pipeline is empty; mirror it in the shadow copy.
	task automatic write_reg(rsg_pkg::cfg_index_t idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			rsg_pkg::CFG_GRID_HEIGHT: grid_h = val[12:0];
			rsg_pkg::CFG_GRID_WIDTH:  grid_w = val[12:0];
			rsg_pkg::CFG_NORM_MODE:   norm_sel = val[1:0];
			default:                  period_cnt = val[8:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_words.size() > 0 || in_valid || expected_embeds.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic push_word(int r, int c, int p, logic [31:0] per);
		pending_words.push_back('{12'(r), 12'(c), 8'(p), per});
	endtask

	// Mostly in-grid positions with useful periods; some out of grid and zero periods.
	task automatic push_random(int n);
		logic [31:0] per;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: per = 0;
				1: per = $urandom;
				2: per = $urandom_range(1, 255);
				default: per = $urandom_range(32'h0000_4000, 32'h0100_0000);
			endcase
			if ($urandom_range(9) == 0)
				push_word(12'($urandom), 12'($urandom), 8'($urandom), per);
			else
				push_word(12'($urandom_range(grid_h > 4096 ? 4095 : grid_h - 1)),
					12'($urandom_range(grid_w > 4096 ? 4095 : grid_w - 1)),
					8'($urandom), per);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, then extremes, bad items and every mode.
		push_word(0, 0, 0, 32'h0001_0000);
		push_word(0, 0, 255, 32'h0001_0000);
		push_word(1, 0, 0, 32'h0001_0000);
		push_word(0, 0, 0, 0);
		drain();
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 4096);
		write_reg(rsg_pkg::CFG_GRID_WIDTH, 4096);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, 256);
		write_reg(rsg_pkg::CFG_NORM_MODE, rsg_pkg::NORM_MIN);
		push_word(0, 0, 0, 1);
		push_word(4095, 4095, 255, 32'hFFFF_FFFF);
		push_word(2048, 2047, 128, 32'h0001_0000);
		push_word(4095, 0, 1, 1);
		push_word(12'hAAA, 12'h555, 8'h55, 32'hAAAA_5555);
		push_word(12'h555, 12'hAAA, 8'hAA, 32'h5555_AAAA);
		drain();
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 8191);
		write_reg(rsg_pkg::CFG_GRID_WIDTH, 3);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, 511);
		write_reg(rsg_pkg::CFG_NORM_MODE, rsg_pkg::NORM_MAX);
		push_word(4095, 2, 255, 32'h0000_8000);
		push_word(0, 3, 0, 32'h0001_0000);
		push_word(1000, 1, 7, 32'h0002_0000);
		drain();
		write_reg(rsg_pkg::CFG_NORM_MODE, 3);
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 0);
		push_word(0, 0, 3, 32'h0001_0000);
		drain();
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 5);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, 1);
		push_word(4, 2, 9, 32'h0000_0001);
		push_word(2, 1, 0, 32'h0001_0000);
		drain();

		// Random phases, each under its own idling mix and setting.
		send_idle = 27; recv_idle = 45;
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 64);
		write_reg(rsg_pkg::CFG_GRID_WIDTH, 48);
		write_reg(rsg_pkg::CFG_NORM_MODE, rsg_pkg::NORM_MIN);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, 32);
		push_random(320);
		wait (pending_words.size() < 160);
		hold_input = 1;  // hold the sender until every word is back
		while (in_valid || expected_embeds.size() > 0) @(posedge clk);
		hold_input = 0;
		drain();

		send_idle = 45; recv_idle = 27;
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 4096);
		write_reg(rsg_pkg::CFG_GRID_WIDTH, 1);
		write_reg(rsg_pkg::CFG_NORM_MODE, rsg_pkg::NORM_MAX);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, 256);
		push_random(310);
		drain();

		send_idle = 0; recv_idle = 0;
		write_reg(rsg_pkg::CFG_GRID_HEIGHT, 1 + $urandom_range(4095));
		write_reg(rsg_pkg::CFG_GRID_WIDTH, 1 + $urandom_range(4095));
		write_reg(rsg_pkg::CFG_NORM_MODE, rsg_pkg::NORM_AXIS);
		write_reg(rsg_pkg::CFG_PERIOD_CNT, $urandom_range(1, 300));
		push_random(320);
		drain();

		$display("covered %0d words (%0d flagged bad) across several register settings",
			words_seen, bad_seen);
		$display("normalize modes min/max/axis/unused, three idling mixes, one full drain hold");
		if (errors == 0 && expected_embeds.size() == 0)
			$display("axial_rope_sincos_generator_top test passed");
		else
			$display("axial_rope_sincos_generator_top test failed");
		$finish;
	end
endmodule

[axial_rope_sincos_generator_top.f]
hw/rtl/rsg_pkg.sv
hw/rtl/rsg_divider.sv
hw/rtl/rsg_cordic.sv
hw/rtl/axial_rope_sincos_generator_top.sv
tb/testbench.sv
